FILE: sv/eze_pkg.sv
// ----------------------------------------------------------------------------
// eze_pkg: shared types and constants of the easing curve evaluator
// Curve and step-position codes, port widths, output limits, sequencer states.
// ----------------------------------------------------------------------------
package eze_pkg;

	// port widths fixed by the item format
	localparam int KIND_W  = 3;
	localparam int COUNT_W = 10;
	localparam int POS_W   = 2;
	localparam int UQ_W    = 17;
	localparam int SQ_W    = 19;

	// output saturation limits (signed Q2.16)
	localparam int OUT_MAX = 262143;
	localparam int OUT_MIN = -262144;

	// curve codes
	localparam logic [KIND_W-1:0] KIND_LINEAR      = 3'd0;
	localparam logic [KIND_W-1:0] KIND_EASE        = 3'd1;
	localparam logic [KIND_W-1:0] KIND_EASE_IN     = 3'd2;
	localparam logic [KIND_W-1:0] KIND_EASE_OUT    = 3'd3;
	localparam logic [KIND_W-1:0] KIND_EASE_IN_OUT = 3'd4;
	localparam logic [KIND_W-1:0] KIND_CUBIC       = 3'd5;
	localparam logic [KIND_W-1:0] KIND_STEPS       = 3'd6;
	localparam logic [KIND_W-1:0] KIND_RSVD        = 3'd7;  // unused, behaves as ease

	// step positions
	localparam logic [POS_W-1:0] POS_JUMP_END   = 2'd0;
	localparam logic [POS_W-1:0] POS_JUMP_START = 2'd1;
	localparam logic [POS_W-1:0] POS_JUMP_NONE  = 2'd2;
	localparam logic [POS_W-1:0] POS_JUMP_BOTH  = 2'd3;

	// sequencer states
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_PRE,
		ST_SQ,
		ST_SQ2,
		ST_CUBE,
		ST_SMUL,
		ST_SDIV,
		ST_B0,
		ST_B1,
		ST_B2,
		ST_B3,
		ST_B4,
		ST_B5,
		ST_B6,
		ST_B7,
		ST_B8,
		ST_D1,
		ST_D2,
		ST_D3,
		ST_DIV,
		ST_OUT
	} eze_state_t;

endpackage

FILE: sv/eze_mul.sv
// ----------------------------------------------------------------------------
// eze_mul: shared fixed-point multiplier
// Signed product scaled down by the fraction width (floor), registered.
// ----------------------------------------------------------------------------
module eze_mul #(
	parameter int IW = 26,
	parameter int F  = 16
) (
	input  logic                 clk,
	input  logic signed [IW-1:0] a,
	input  logic signed [IW-1:0] b,
	output logic signed [IW-1:0] p
);

	logic signed [2*IW-1:0] prod;
	logic signed [IW-1:0]   p_q;

	// full product, arithmetic shift rounds toward minus infinity
	assign prod = a * b;

	always_ff @(posedge clk) begin
		p_q <= IW'(prod >>> F);
	end

	assign p = p_q;

endmodule

FILE: sv/eze_div.sv
// ----------------------------------------------------------------------------
// eze_div: shared signed divider
// Restoring division, one quotient bit per cycle, truncation toward zero.
// ----------------------------------------------------------------------------
module eze_div #(
	parameter int DW = 46,
	parameter int VW = 30
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [DW-1:0] dividend,
	input  logic signed [VW-1:0] divisor,
	output logic                 busy,
	output logic                 done,
	output logic signed [DW:0]   quotient
);

	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0] quo_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] dvs_q;
	logic          neg_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [DW-1:0] dnd_mag;
	logic [VW-1:0] dvs_mag;
	logic [VW:0]   trial;
	logic          fits;

	// operand magnitudes
	assign dnd_mag = dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
	assign dvs_mag = divisor[VW-1] ? VW'(-divisor) : VW'(divisor);

	// trial subtract of one step
	assign trial = {rem_q, quo_q[DW-1]};
	assign fits  = (trial >= {1'b0, dvs_q});

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dnd_mag;
			rem_q <= '0;
			dvs_q <= dvs_mag;
			neg_q <= dividend[DW-1] ^ divisor[VW-1];
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], fits};
			rem_q <= fits ? VW'(trial - {1'b0, dvs_q}) : VW'(trial);
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

endmodule

FILE: sv/easing_curve_evaluator_core.sv
// ----------------------------------------------------------------------------
// easing_curve_evaluator_core: eased value of one progress sample
// Linear, ease, quadratic, cubic Bezier and step curves in fixed point.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel (in_valid / in_stall) carries one beat: curve descriptor and
//  progress. Output channel (out_valid / out_stall) returns one eased value
//  per input beat. in_stall stays high from the accepted beat until its
//  result has been taken, so one item is in flight at a time.
//  Linear curves and clamped ends go straight to the output; quadratic curves
//  take one square and ease a square and a cube; steps take one multiply and a
//  division; cubic Bezier runs up to NEWTON_ITERATIONS Newton updates, each
//  with a division, and stops early on a zero error or a zero slope.
//  The run time of a beat is set by the bit-serial divider, one quotient bit
//  per cycle, and the single multiplier that every product of an iteration
//  goes through.
//  A stalled result holds in its register; the next beat is taken in the
//  cycle after the result is accepted.
//  Reset (arst_n low) returns the sequencer to idle and drops out_valid.
// ----------------------------------------------------------------------------
module easing_curve_evaluator_core
	import eze_pkg::*;
#(
	parameter int FRAC_BITS         = 16,
	parameter int NEWTON_ITERATIONS = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [KIND_W-1:0]        curve_kind,
	input  logic [COUNT_W-1:0]       step_count,
	input  logic [POS_W-1:0]         step_position,
	input  logic [UQ_W-1:0]          ctrl_x1,
	input  logic signed [SQ_W-1:0]   ctrl_y1,
	input  logic [UQ_W-1:0]          ctrl_x2,
	input  logic signed [SQ_W-1:0]   ctrl_y2,
	input  logic [UQ_W-1:0]          progress,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [SQ_W-1:0]   eased_value
);

	localparam int F    = FRAC_BITS;
	localparam int IW   = F + 10;
	localparam int AW   = IW + 4;
	localparam int DW   = AW + F;
	localparam int IT_W = $clog2(NEWTON_ITERATIONS + 1);
	localparam int NW   = COUNT_W + 1;

	localparam logic signed [IW-1:0] ONE    = IW'(1) <<< F;
	localparam logic signed [AW-1:0] ONE_A  = AW'(1) <<< F;

	eze_state_t state_q, state_d;

	// captured item
	logic [KIND_W-1:0]    kind_q;
	logic [POS_W-1:0]     pos_q;
	logic [NW-1:0]        n_q;
	logic signed [IW-1:0] x_q, x1_q, x2_q, y1_q, y2_q;

	// working registers
	logic signed [IW-1:0] t_q, r1_q, r2_q, r3_q, a_q, b_q, c_q;
	logic signed [AW-1:0] acc_q, err_q, dq_q, res_q;
	logic [IT_W-1:0]      iter_q;
	logic                 yph_q;

	// shared units
	logic signed [IW-1:0] mul_a, mul_b, mr;
	logic                 div_start, div_busy, div_done;
	logic signed [DW-1:0] div_dnd;
	logic signed [AW-1:0] div_dvs;
	logic signed [DW:0]   div_q;

	// derived values
	logic                 accept, half, is_ease;
	logic signed [IW-1:0] m_x, mt, v;
	logic signed [AW-1:0] mr_a, mr3, sum, err, dsum;
	logic [NW-1:0]        jumps, step_raw, step;
	logic signed [DW:0]   tn;
	logic signed [IW-1:0] px, ix1, ix2, iy1, iy2;

	eze_mul #(.IW(IW), .F(F)) u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mr)
	);

	eze_div #(.DW(DW), .VW(AW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dnd),
		.divisor  (div_dvs),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_q)
	);

	assign accept = in_valid && !in_stall;

	// input widening and clamping
	assign px  = IW'(progress);
	assign ix1 = IW'(ctrl_x1);
	assign ix2 = IW'(ctrl_x2);
	assign iy1 = IW'(ctrl_y1);
	assign iy2 = IW'(ctrl_y2);

	// curve helpers
	assign m_x     = ONE - x_q;
	assign mt      = ONE - t_q;
	assign half    = (x_q <<< 1) < ONE;
	assign is_ease = !(kind_q inside {KIND_EASE_IN, KIND_EASE_OUT, KIND_EASE_IN_OUT});

	always_comb begin
		case (kind_q)
			KIND_EASE_IN:     v = x_q;
			KIND_EASE_OUT:    v = m_x;
			KIND_EASE_IN_OUT: v = half ? x_q : m_x;
			default:          v = half ? x_q : (m_x <<< 1);
		endcase
	end

	// Bezier sums
	assign mr_a = AW'(mr);
	assign mr3  = mr_a + (mr_a <<< 1);
	assign sum  = acc_q + mr3 + AW'(c_q);
	assign err  = sum - AW'(x_q);
	assign dsum = dq_q + mr3;

	// Newton update of the curve parameter
	assign tn = (DW+1)'(t_q) - div_q;

	// step index and jump count
	always_comb begin
		case (pos_q)
			POS_JUMP_NONE: jumps = (n_q > NW'(1)) ? n_q - NW'(1) : NW'(1);
			POS_JUMP_BOTH: jumps = n_q + NW'(1);
			default:       jumps = n_q;
		endcase
		step_raw = NW'(mr) + ((pos_q == POS_JUMP_START || pos_q == POS_JUMP_BOTH) ?
			NW'(1) : NW'(0));
		step = (step_raw > jumps) ? jumps : step_raw;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_PRE;
			ST_PRE: begin
				if (kind_q == KIND_STEPS)
					state_d = ST_SMUL;
				else if (x_q == '0 || x_q >= ONE || kind_q == KIND_LINEAR)
					state_d = ST_OUT;
				else if (kind_q == KIND_CUBIC)
					state_d = ST_B0;
				else
					state_d = ST_SQ;
			end
			ST_SQ:   state_d = ST_SQ2;
			ST_SQ2:  state_d = is_ease ? ST_CUBE : ST_OUT;
			ST_CUBE: state_d = ST_OUT;
			ST_SMUL: state_d = ST_SDIV;
			ST_SDIV: state_d = ST_DIV;
			ST_B0:   state_d = ST_B1;
			ST_B1:   state_d = ST_B2;
			ST_B2:   state_d = ST_B3;
			ST_B3:   state_d = ST_B4;
			ST_B4:   state_d = ST_B5;
			ST_B5:   state_d = ST_B6;
			ST_B6:   state_d = ST_B7;
			ST_B7:   state_d = ST_B8;
			ST_B8: begin
				if (yph_q)
					state_d = ST_OUT;
				else if (err == '0)
					state_d = ST_B0;
				else
					state_d = ST_D1;
			end
			ST_D1: state_d = ST_D2;
			ST_D2: state_d = ST_D3;
			ST_D3: state_d = (dsum == '0) ? ST_B0 : ST_DIV;
			ST_DIV: begin
				if (div_done)
					state_d = (kind_q == KIND_STEPS) ? ST_OUT : ST_B0;
			end
			ST_OUT:  if (!out_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs and shared-unit controls
	always_comb begin
		mul_a     = x_q;
		mul_b     = x_q;
		div_start = 1'b0;
		div_dnd   = {err_q, F'(0)};
		div_dvs   = dsum;
		in_stall  = (state_q != ST_IDLE);
		out_valid = (state_q == ST_OUT);
		case (state_q)
			ST_SQ: begin
				mul_a = v;
				mul_b = v;
			end
			ST_SQ2: begin
				mul_a = mr;
				mul_b = v;
			end
			ST_SMUL: begin
				mul_a = x_q;
				mul_b = IW'(n_q);
			end
			ST_SDIV: begin
				div_start = 1'b1;
				div_dnd   = DW'(step) <<< F;
				div_dvs   = AW'(jumps);
			end
			ST_B0: begin
				mul_a = mt;
				mul_b = mt;
			end
			ST_B1: begin
				mul_a = mt;
				mul_b = t_q;
			end
			ST_B2: begin
				mul_a = t_q;
				mul_b = t_q;
			end
			ST_B3: begin
				mul_a = r1_q;
				mul_b = t_q;
			end
			ST_B4: begin
				mul_a = r2_q;
				mul_b = t_q;
			end
			ST_B5: begin
				mul_a = r3_q;
				mul_b = t_q;
			end
			ST_B6: begin
				mul_a = a_q;
				mul_b = yph_q ? y1_q : x1_q;
			end
			ST_B7: begin
				mul_a = b_q;
				mul_b = yph_q ? y2_q : x2_q;
			end
			ST_B8: begin
				mul_a = r1_q;
				mul_b = x1_q;
			end
			ST_D1: begin
				mul_a = r2_q;
				mul_b = x2_q - x1_q;
			end
			ST_D2: begin
				mul_a = r3_q;
				mul_b = ONE - x2_q;
			end
			ST_D3: div_start = (dsum != '0);
			default: ;
		endcase
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			iter_q  <= '0;
			yph_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_PRE: begin
					iter_q <= '0;
					yph_q  <= 1'b0;
				end
				ST_B8:  if (!yph_q && err == '0) yph_q <= 1'b1;
				ST_D3:  if (dsum == '0) yph_q <= 1'b1;
				ST_DIV: begin
					if (div_done && kind_q != KIND_STEPS) begin
						iter_q <= iter_q + 1'b1;
						if (iter_q == IT_W'(NEWTON_ITERATIONS - 1))
							yph_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= curve_kind;
			pos_q  <= step_position;
			n_q    <= (step_count == '0) ? NW'(1) : NW'(step_count);
			x_q    <= (px > ONE) ? ONE : px;
			x1_q   <= (ix1 > ONE) ? ONE : ix1;
			x2_q   <= (ix2 > ONE) ? ONE : ix2;
			y1_q   <= iy1;
			y2_q   <= iy2;
		end
		case (state_q)
			ST_PRE: begin
				t_q <= x_q;
				if (x_q == '0)
					res_q <= '0;
				else if (x_q >= ONE)
					res_q <= ONE_A;
				else
					res_q <= AW'(x_q);
			end
			ST_SQ2: begin
				case (kind_q)
					KIND_EASE_IN:     res_q <= mr_a;
					KIND_EASE_OUT:    res_q <= ONE_A - mr_a;
					KIND_EASE_IN_OUT: res_q <= half ? (mr_a <<< 1) : ONE_A - (mr_a <<< 1);
					default:          res_q <= res_q;
				endcase
			end
			ST_CUBE: res_q <= half ? (mr_a <<< 2) : ONE_A - (mr_a >>> 1);
			ST_B1: r1_q <= mr;
			ST_B2: r2_q <= mr;
			ST_B3: r3_q <= mr;
			ST_B4: a_q  <= mr;
			ST_B5: b_q  <= mr;
			ST_B6: c_q  <= mr;
			ST_B7: acc_q <= mr3;
			ST_B8: begin
				err_q <= err;
				if (yph_q)
					res_q <= sum;
			end
			ST_D1: dq_q <= mr3;
			ST_D2: dq_q <= dq_q + (mr_a <<< 2) + (mr_a <<< 1);
			ST_DIV: begin
				if (div_done) begin
					if (kind_q == KIND_STEPS)
						res_q <= AW'(div_q);
					else if (tn < 0)
						t_q <= '0;
					else if (tn > (DW+1)'(ONE))
						t_q <= ONE;
					else
						t_q <= IW'(tn);
				end
			end
			default: ;
		endcase
	end

	// saturate to the output range
	always_comb begin
		if (res_q > AW'(OUT_MAX))
			eased_value = SQ_W'(OUT_MAX);
		else if (res_q < AW'(OUT_MIN))
			eased_value = SQ_W'(OUT_MIN);
		else
			eased_value = SQ_W'(res_q);
	end

`ifndef SYNTHESIS
	// a finished result blocks new beats
	a_out_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while a result is pending");

	// divider runs after every start
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> div_busy)
		else $error("divider did not start");

	// no start while the divider works
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider restarted while busy");

	// Newton parameter stays in [0, 1] at each pass
	a_t_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_B0) |-> (t_q >= 0 && t_q <= ONE))
		else $error("Bezier parameter out of range");

	// iteration count bounded
	a_iter: assert property (@(posedge clk) disable iff (!arst_n)
		iter_q <= IT_W'(NEWTON_ITERATIONS))
		else $error("too many Newton iterations");
`endif

endmodule

FILE: verif/easing_curve_evaluator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// easing_curve_evaluator_core_tb: self-checking bench of the easing evaluator
// Directed table of curve extremes and step cases, then random descriptors;
// every eased value is compared against a table value or an in-bench predictor.
// ----------------------------------------------------------------------------
module easing_curve_evaluator_core_tb;
	import eze_pkg::*;

	localparam longint ONE = 64'sd65536;
	localparam int N_RAND = 2000;

	typedef struct {
		logic [KIND_W-1:0]      kind;
		logic [COUNT_W-1:0]     cnt;
		logic [POS_W-1:0]       pos;
		logic [UQ_W-1:0]        x1;
		logic signed [SQ_W-1:0] y1;
		logic [UQ_W-1:0]        x2;
		logic signed [SQ_W-1:0] y2;
		logic [UQ_W-1:0]        prog;
		bit                     has_val;
		logic signed [SQ_W-1:0] val;
	} curve_beat_t;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	logic [KIND_W-1:0]      curve_kind;
	logic [COUNT_W-1:0]     step_count;
	logic [POS_W-1:0]       step_position;
	logic [UQ_W-1:0]        ctrl_x1;
	logic signed [SQ_W-1:0] ctrl_y1;
	logic [UQ_W-1:0]        ctrl_x2;
	logic signed [SQ_W-1:0] ctrl_y2;
	logic [UQ_W-1:0]        progress;
	logic                   out_valid;
	logic                   out_stall;
	logic signed [SQ_W-1:0] eased_value;

	logic signed [SQ_W-1:0] eased_q[$];
	int                     n_err;
	bit                     calm;      // no idling in the last part
	bit                     hold_req;  // ask the receiver for a long hold-off

	easing_curve_evaluator_core dut (.*);

	// clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------
	// product rounded toward minus infinity
	function automatic longint qm(longint a, longint b);
		return (a * b) >>> 16;
	endfunction

	function automatic longint bez_coord(longint t, longint p1, longint p2);
		longint mt;
		mt = ONE - t;
		return 3 * qm(qm(qm(mt, mt), t), p1) + 3 * qm(qm(qm(mt, t), t), p2)
			+ qm(qm(t, t), t);
	endfunction

	// Newton inversion of the x axis, then y at the found parameter
	function automatic longint bez_invert(longint x, longint x1, longint y1,
			longint x2, longint y2);
		longint t, err, mt, d;
		t = x;
		for (int i = 0; i < 8; i++) begin
			err = bez_coord(t, x1, x2) - x;
			if (err == 0) break;
			mt = ONE - t;
			d = 3 * qm(qm(mt, mt), x1) + 6 * qm(qm(mt, t), x2 - x1)
				+ 3 * qm(qm(t, t), ONE - x2);
			if (d == 0) break;
			t = t - (err * ONE) / d;
			if (t < 0) t = 0;
			if (t > ONE) t = ONE;
		end
		return bez_coord(t, y1, y2);
	endfunction

	function automatic longint step_value(longint n, logic [POS_W-1:0] pos, longint x);
		longint idx, jumps;
		if (n < 1) n = 1;
		idx = (x * n) >> 16;
		if (pos == POS_JUMP_START || pos == POS_JUMP_BOTH) idx++;
		jumps = n;
		if (pos == POS_JUMP_NONE) jumps = (n > 1) ? n - 1 : 1;
		else if (pos == POS_JUMP_BOTH) jumps = n + 1;
		if (idx > jumps) idx = jumps;
		return (idx * ONE) / jumps;
	endfunction

	function automatic logic signed [SQ_W-1:0] ease_predict(curve_beat_t b);
		longint x, x1, x2, m, r, u;
		x  = longint'(b.prog);
		x1 = longint'(b.x1);
		x2 = longint'(b.x2);
		if (x > ONE) x = ONE;
		if (x1 > ONE) x1 = ONE;
		if (x2 > ONE) x2 = ONE;
		m = ONE - x;
		if (b.kind == KIND_STEPS) r = step_value(longint'(b.cnt), b.pos, x);
		else if (x == 0) r = 0;
		else if (x == ONE) r = ONE;
		else begin
			case (b.kind)
				KIND_LINEAR:      r = x;
				KIND_EASE_IN:     r = qm(x, x);
				KIND_EASE_OUT:    r = ONE - qm(m, m);
				KIND_EASE_IN_OUT: r = (2 * x < ONE) ? 2 * qm(x, x) : ONE - 2 * qm(m, m);
				KIND_CUBIC:       r = bez_invert(x, x1, longint'(b.y1), x2, longint'(b.y2));
				default: begin
					// ease, and the unused code that behaves as ease
					if (2 * x < ONE) r = 4 * qm(qm(x, x), x);
					else begin
						u = 2 * m;
						r = ONE - (qm(qm(u, u), u) >> 1);
					end
				end
			endcase
		end
		if (r > OUT_MAX) r = OUT_MAX;
		if (r < OUT_MIN) r = OUT_MIN;
		return r[SQ_W-1:0];
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	function automatic curve_beat_t row(logic [KIND_W-1:0] k, int c, logic [POS_W-1:0] p,
			int ax1, int ay1, int ax2, int ay2, int pr, bit hv, int v);
		curve_beat_t b;
		b.kind = k; b.cnt = COUNT_W'(c); b.pos = p;
		b.x1 = UQ_W'(ax1); b.y1 = SQ_W'(ay1); b.x2 = UQ_W'(ax2); b.y2 = SQ_W'(ay2);
		b.prog = UQ_W'(pr); b.has_val = hv; b.val = SQ_W'(v);
		return b;
	endfunction

	function automatic logic [UQ_W-1:0] rand_uq();
		int s;
		s = $urandom_range(0, 99);
		if (s < 5) return '0;
		if (s < 10) return UQ_W'(ONE);
		if (s < 18) return UQ_W'($urandom_range(65537, 131071));
		return UQ_W'($urandom_range(0, 65536));
	endfunction

	function automatic curve_beat_t rand_beat();
		curve_beat_t b;
		int s;
		s = $urandom_range(0, 99);
		if (s < 20) b.kind = KIND_CUBIC;
		else if (s < 40) b.kind = KIND_STEPS;
		else b.kind = KIND_W'($urandom_range(0, 7));
		s = $urandom_range(0, 9);
		b.cnt = COUNT_W'((s < 7) ? $urandom_range(0, 12) : $urandom_range(0, 1023));
		b.pos = POS_W'($urandom_range(0, 3));
		b.x1 = rand_uq();
		b.x2 = rand_uq();
		s = $urandom_range(0, 9);
		b.y1 = SQ_W'((s < 7) ? $urandom_range(0, 196608) - 65536 : $urandom);
		s = $urandom_range(0, 9);
		b.y2 = SQ_W'((s < 7) ? $urandom_range(0, 196608) - 65536 : $urandom);
		b.prog = rand_uq();
		b.has_val = 0;
		b.val = '0;
		return b;
	endfunction

	// one beat offered until the block takes it
	task automatic send_beat(curve_beat_t b);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		curve_kind    <= b.kind;
		step_count    <= b.cnt;
		step_position <= b.pos;
		ctrl_x1       <= b.x1;
		ctrl_y1       <= b.y1;
		ctrl_x2       <= b.x2;
		ctrl_y2       <= b.y2;
		progress      <= b.prog;
		in_valid      <= 1'b1;
		do @(posedge clk); while (in_stall);
		eased_q.push_back(b.has_val ? b.val : ease_predict(b));
	endtask

	// ------------------------------------------------------------------
	// sender
	// ------------------------------------------------------------------
	curve_beat_t dir_tbl[$];

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		curve_kind = '0; step_count = '0; step_position = '0;
		ctrl_x1 = '0; ctrl_y1 = '0; ctrl_x2 = '0; ctrl_y2 = '0; progress = '0;
		n_err = 0;
		calm = 0;
		hold_req = 0;

		// clamped ends, out-of-range progress, zero steps, jump counts
		dir_tbl.push_back(row(KIND_LINEAR, 0, POS_JUMP_END, 0, 0, 0, 0, 0, 1, 0));
		dir_tbl.push_back(row(KIND_LINEAR, 0, POS_JUMP_END, 0, 0, 0, 0, 65536, 1, 65536));
		dir_tbl.push_back(row(KIND_EASE, 0, POS_JUMP_END, 0, 0, 0, 0, 131071, 1, 65536));
		dir_tbl.push_back(row(KIND_CUBIC, 0, POS_JUMP_END, 131071, -262144, 131071,
			262143, 0, 1, 0));
		dir_tbl.push_back(row(KIND_CUBIC, 0, POS_JUMP_END, 0, 262143, 0, -262144,
			131071, 1, 65536));
		dir_tbl.push_back(row(KIND_STEPS, 0, POS_JUMP_END, 0, 0, 0, 0, 0, 1, 0));
		dir_tbl.push_back(row(KIND_STEPS, 0, POS_JUMP_START, 0, 0, 0, 0, 0, 1, 65536));
		dir_tbl.push_back(row(KIND_STEPS, 1, POS_JUMP_NONE, 0, 0, 0, 0, 65536, 1, 65536));
		dir_tbl.push_back(row(KIND_STEPS, 1023, POS_JUMP_BOTH, 0, 0, 0, 0, 131071,
			1, 65536));
		dir_tbl.push_back(row(KIND_STEPS, 1023, POS_JUMP_END, 0, 0, 0, 0, 65536,
			1, 65536));
		// interior points, checked against the predictor
		dir_tbl.push_back(row(KIND_LINEAR, 0, POS_JUMP_END, 0, 0, 0, 0, 1, 0, 0));
		dir_tbl.push_back(row(KIND_EASE, 0, POS_JUMP_END, 0, 0, 0, 0, 20000, 0, 0));
		dir_tbl.push_back(row(KIND_EASE, 0, POS_JUMP_END, 0, 0, 0, 0, 32768, 0, 0));
		dir_tbl.push_back(row(KIND_EASE_IN, 0, POS_JUMP_END, 0, 0, 0, 0, 65535, 0, 0));
		dir_tbl.push_back(row(KIND_EASE_OUT, 0, POS_JUMP_END, 0, 0, 0, 0, 1000, 0, 0));
		dir_tbl.push_back(row(KIND_EASE_IN_OUT, 0, POS_JUMP_END, 0, 0, 0, 0, 32767, 0, 0));
		dir_tbl.push_back(row(KIND_EASE_IN_OUT, 0, POS_JUMP_END, 0, 0, 0, 0, 32768, 0, 0));
		dir_tbl.push_back(row(KIND_RSVD, 0, POS_JUMP_END, 0, 0, 0, 0, 50000, 0, 0));
		dir_tbl.push_back(row(KIND_CUBIC, 0, POS_JUMP_END, 16384, 6554, 16384, 65536,
			30000, 0, 0));
		dir_tbl.push_back(row(KIND_CUBIC, 0, POS_JUMP_END, 131071, 262143, 131071,
			262143, 40000, 0, 0));
		dir_tbl.push_back(row(KIND_CUBIC, 0, POS_JUMP_END, 0, -262144, 0, -262144,
			32768, 0, 0));
		dir_tbl.push_back(row(KIND_CUBIC, 0, POS_JUMP_END, 0, 0, 65536, 65536, 12345, 0, 0));
		dir_tbl.push_back(row(KIND_STEPS, 3, POS_JUMP_NONE, 0, 0, 0, 0, 30000, 0, 0));
		dir_tbl.push_back(row(KIND_STEPS, 5, POS_JUMP_BOTH, 0, 0, 0, 0, 40000, 0, 0));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tbl[i]) send_beat(dir_tbl[i]);

		for (int i = 0; i < N_RAND; i++) begin
			if (i == 500) hold_req <= 1'b1;
			if (i == 1000) begin
				// drain the result path before going on
				in_valid <= 1'b0;
				while (eased_q.size() != 0) @(posedge clk);
			end
			if (i == N_RAND - 200) calm <= 1'b1;
			send_beat(rand_beat());
		end
		in_valid <= 1'b0;

		while (eased_q.size() != 0) @(posedge clk);
		repeat (600) @(posedge clk);
		if (n_err == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// ------------------------------------------------------------------
	// receiver stall: short bursts, one long hold-off on request
	// ------------------------------------------------------------------
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req <= 1'b0;
				out_stall <= 1'b1;
				repeat (1500) @(posedge clk);
				out_stall <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 3)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// result check against the oldest expectation
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		logic signed [SQ_W-1:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (eased_q.size() == 0) begin
				n_err++;
				if (n_err <= 10)
					$display("unexpected beat: eased_value=%0d", eased_value);
			end else begin
				want = eased_q.pop_front();
				if (eased_value !== want) begin
					n_err++;
					if (n_err <= 10)
						$display("mismatch: eased_value exp=%0d got=%0d", want, eased_value);
				end
			end
		end
	end

	// run limit
	initial begin
		#60_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
